// ----- rtl/knn_sel_pkg.sv -----
// Shared types, widths and register codes of the k-nearest-neighbor selector.
package knn_sel_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int COORD_BITS    = 16;
    localparam int DIST_W        = 2 * COORD_BITS + 1;
    localparam int SQ_W          = 2 * COORD_BITS;
    localparam int K_W           = 5;
    localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
    localparam int CMP_W         = (CNT_W > K_W) ? CNT_W : K_W;
    localparam int CFG_W         = (COORD_BITS > K_W) ? COORD_BITS : K_W;
    localparam int IDX_W         = 2;

    localparam logic [IDX_W-1:0] REG_K_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_QUERY_X = 2'd1;
    localparam logic [IDX_W-1:0] REG_QUERY_Y = 2'd2;

    localparam logic [K_W-1:0] K_COUNT_RESET = 5'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  final_point;
    } point_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] near_x;
        logic [COORD_BITS-1:0] near_y;
        logic [DIST_W-1:0]     near_distance;
        logic                  last_of_run;
    } neighbor_out_t;

    // One kept list entry.
    typedef struct packed {
        logic [DIST_W-1:0]     distance;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } entry_t;

    // Measured point waiting to be inserted into the list.
    typedef struct packed {
        entry_t entry;
        logic   final_point;
    } measured_t;

    // Status that one cell hands to the next cell of the chain.
    typedef struct packed {
        logic valid;
        logic gt;
    } link_t;

endpackage

// ----- rtl/knn_sel_dist.sv -----
// Three-stage distance pipeline: absolute differences, squares, sum.
module knn_sel_dist
    import knn_sel_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  stall,
    input  logic                  in_valid,
    input  point_in_t             in_data,
    input  logic [COORD_BITS-1:0] query_x,
    input  logic [COORD_BITS-1:0] query_y,
    output logic                  out_valid,
    output measured_t             out_data
);

    logic                  a_valid_reg, b_valid_reg, c_valid_reg;
    logic [COORD_BITS-1:0] a_dx_reg, a_dy_reg;
    logic [COORD_BITS-1:0] a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic                  a_final_reg, b_final_reg;
    logic [SQ_W-1:0]       b_sqx_reg, b_sqy_reg;
    measured_t             c_data_reg;
    logic [COORD_BITS-1:0] dx_next, dy_next;

    always_comb begin
        dx_next = (in_data.point_x >= query_x) ? (in_data.point_x - query_x)
                                               : (query_x - in_data.point_x);
        dy_next = (in_data.point_y >= query_y) ? (in_data.point_y - query_y)
                                               : (query_y - in_data.point_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (!stall) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            a_dx_reg    <= dx_next;
            a_dy_reg    <= dy_next;
            a_x_reg     <= in_data.point_x;
            a_y_reg     <= in_data.point_y;
            a_final_reg <= in_data.final_point;

            b_sqx_reg   <= SQ_W'(a_dx_reg) * SQ_W'(a_dx_reg);
            b_sqy_reg   <= SQ_W'(a_dy_reg) * SQ_W'(a_dy_reg);
            b_x_reg     <= a_x_reg;
            b_y_reg     <= a_y_reg;
            b_final_reg <= a_final_reg;

            c_data_reg.entry.distance <= DIST_W'(b_sqx_reg) + DIST_W'(b_sqy_reg);
            c_data_reg.entry.x        <= b_x_reg;
            c_data_reg.entry.y        <= b_y_reg;
            c_data_reg.final_point    <= b_final_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

// ----- rtl/knn_sel_cell.sv -----
// One cell of the sorted insertion chain.
module knn_sel_cell
    import knn_sel_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   update,
    input  logic   clear,
    input  logic   keep,
    input  entry_t new_entry,
    input  link_t  prev_link,
    input  entry_t prev_entry,
    output link_t  link,
    output entry_t entry,
    output logic   valid_next,
    output entry_t entry_next
);

    logic   valid_reg;
    entry_t entry_reg;
    logic   take_new;
    logic   take_shift;
    logic   gt;

    always_comb begin
        gt         = valid_reg && (entry_reg.distance > new_entry.distance);
        // The new point lands right after the last entry that is not farther.
        take_new   = prev_link.valid && !prev_link.gt && !(valid_reg && !gt);
        take_shift = prev_link.gt;
        priority if (take_shift) begin
            entry_next = prev_entry;
        end else if (take_new) begin
            entry_next = new_entry;
        end else begin
            entry_next = entry_reg;
        end
        valid_next = keep && (valid_reg || take_new || take_shift);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (update) begin
            valid_reg <= valid_next && !clear;
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            entry_reg <= entry_next;
        end
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign entry      = entry_reg;

endmodule

// ----- rtl/knn_sel_drain_cell.sv -----
// One cell of the output bank, loaded in parallel and shifted toward the port.
module knn_sel_drain_cell
    import knn_sel_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load,
    input  logic   shift,
    input  logic   load_valid,
    input  entry_t load_entry,
    input  logic   up_valid,
    input  entry_t up_entry,
    output logic   valid,
    output entry_t entry
);

    logic   valid_reg;
    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= load_valid;
        end else if (shift) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= load_entry;
        end else if (shift) begin
            entry_reg <= up_entry;
        end
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ----- rtl/k_nearest_neighbor_select.sv -----
// Top level of the k-nearest-neighbor selector.
//
// Points enter on the s_ channel, one item per cycle unless the input is
// stalled, and are measured by squared Euclidean distance against the query
// point. A chain of cells keeps the k nearest in order; every cell compares
// against the new distance in parallel, so a point is inserted every cycle
// the input is not stalled. Equal distances keep arrival order. The cfg
// channel writes k_count (index 0), query_x (1) and query_y (2) and is
// always ready; write it only while the block is idle.
// A point is measured in the distance pipeline (absolute differences, squares,
// sum) and then inserted. On the point marked final_point the whole list moves
// into an output bank and the chain starts empty, so the first result is valid
// on the m_ channel once the final item is inserted, then one result per cycle
// while m_ready is high, nearest first; last_of_run marks the farthest.
// Ordinary points keep flowing while results drain. A final point waits at the
// insertion stage, holding s_ready low, while the output bank holds results,
// unless only its last one is left and leaves in that cycle; a stalled
// receiver therefore stalls the input once another final point arrives.
// Reset empties the list and the output bank and sets k_count to 3 and the
// query point to the origin.
module k_nearest_neighbor_select
    import knn_sel_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  point_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output neighbor_out_t         m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [K_W-1:0]        k_count_reg;
    logic [COORD_BITS-1:0] query_x_reg, query_y_reg;
    logic [CMP_W-1:0]      k_eff;

    logic                  ins_valid;
    measured_t             ins_data;
    logic                  stall, ins_fire, load, shift, bank_busy;

    link_t                 links       [MAX_NEIGHBORS+1];
    entry_t                entries     [MAX_NEIGHBORS+1];
    logic                  cell_vnext  [MAX_NEIGHBORS];
    entry_t                cell_enext  [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] keep_mask;

    logic                  bank_valid  [MAX_NEIGHBORS+1];
    entry_t                bank_entry  [MAX_NEIGHBORS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_count_reg <= K_COUNT_RESET;
            query_x_reg <= '0;
            query_y_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_K_COUNT: k_count_reg <= cfg_data[K_W-1:0];
                REG_QUERY_X: query_x_reg <= cfg_data[COORD_BITS-1:0];
                REG_QUERY_Y: query_y_reg <= cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp k to 1..MAX_NEIGHBORS.
    always_comb begin
        priority if (k_count_reg == '0) begin
            k_eff = CMP_W'(1);
        end else if (CMP_W'(k_count_reg) > CMP_W'(MAX_NEIGHBORS)) begin
            k_eff = CMP_W'(MAX_NEIGHBORS);
        end else begin
            k_eff = CMP_W'(k_count_reg);
        end
    end

    // The bank can take a new list once at most its last result is left
    // and that one leaves now.
    assign bank_busy = bank_valid[0] && !(m_ready && !bank_valid[1]);
    assign stall     = ins_valid && ins_data.final_point && bank_busy;
    assign s_ready   = !stall;
    assign ins_fire  = ins_valid && !stall;
    assign load      = ins_fire && ins_data.final_point;
    assign shift     = m_valid && m_ready;

    knn_sel_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stall     (stall),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .query_x   (query_x_reg),
        .query_y   (query_y_reg),
        .out_valid (ins_valid),
        .out_data  (ins_data)
    );

    assign links[0].valid = 1'b1;
    assign links[0].gt    = 1'b0;
    assign entries[0]     = ins_data.entry;

    assign bank_valid[MAX_NEIGHBORS] = 1'b0;
    assign bank_entry[MAX_NEIGHBORS] = '0;

    for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
        assign keep_mask[i] = CMP_W'(i) < k_eff;

        knn_sel_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .update     (ins_fire),
            .clear      (load),
            .keep       (keep_mask[i]),
            .new_entry  (ins_data.entry),
            .prev_link  (links[i]),
            .prev_entry (entries[i]),
            .link       (links[i+1]),
            .entry      (entries[i+1]),
            .valid_next (cell_vnext[i]),
            .entry_next (cell_enext[i])
        );

        knn_sel_drain_cell u_drain (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load       (load),
            .shift      (shift),
            .load_valid (cell_vnext[i]),
            .load_entry (cell_enext[i]),
            .up_valid   (bank_valid[i+1]),
            .up_entry   (bank_entry[i+1]),
            .valid      (bank_valid[i]),
            .entry      (bank_entry[i])
        );
    end

    assign m_valid              = bank_valid[0];
    assign m_data.near_x        = bank_entry[0].x;
    assign m_data.near_y        = bank_entry[0].y;
    assign m_data.near_distance = bank_entry[0].distance;
    assign m_data.last_of_run   = !bank_valid[1];

endmodule

// ----- tb/knn_sel_checker.sv -----
// Checker for the k-nearest-neighbor selector: predicts and compares each reported neighbor.
`timescale 1ns / 100ps

module knn_sel_checker
    import knn_sel_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  point_in_t        s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  neighbor_out_t    m_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               pending_results,
    output int               mismatch_count
);

    logic [K_W-1:0]        k_reg;
    logic [COORD_BITS-1:0] query_x_reg;
    logic [COORD_BITS-1:0] query_y_reg;
    entry_t                nearest_list [MAX_NEIGHBORS];
    int                    list_fill;
    neighbor_out_t         expected_neighbors [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] neighbor mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int keep_limit();
        if (k_reg == '0) begin
            return 1;
        end
        if (int'(k_reg) > MAX_NEIGHBORS) begin
            return MAX_NEIGHBORS;
        end
        return int'(k_reg);
    endfunction

    task automatic clear_list();
        int i;
        for (i = 0; i < MAX_NEIGHBORS; i++) begin
            nearest_list[i] = '0;
        end
        list_fill = 0;
    endtask

    // Sorted insertion: the new point goes after every entry of equal or
    // smaller distance, and the list is then cut to the current k.
    task automatic insert_point(input point_in_t pt);
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [DIST_W-1:0]     point_dist;
        neighbor_out_t         nb;
        int                    n;
        int                    pos;
        int                    top;
        int                    i;
        dx = (pt.point_x >= query_x_reg) ? pt.point_x - query_x_reg : query_x_reg - pt.point_x;
        dy = (pt.point_y >= query_y_reg) ? pt.point_y - query_y_reg : query_y_reg - pt.point_y;
        point_dist = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
        n = list_fill;
        pos = 0;
        while (pos < n && nearest_list[pos].distance <= point_dist) begin
            pos++;
        end
        if (pos < MAX_NEIGHBORS) begin
            top = (n < MAX_NEIGHBORS) ? n : MAX_NEIGHBORS - 1;
            for (i = top; i > pos; i--) begin
                nearest_list[i] = nearest_list[i-1];
            end
            nearest_list[pos].distance = point_dist;
            nearest_list[pos].x        = pt.point_x;
            nearest_list[pos].y        = pt.point_y;
            if (n < MAX_NEIGHBORS) begin
                n++;
            end
        end
        if (n > keep_limit()) begin
            n = keep_limit();
        end
        list_fill = n;
        if (pt.final_point) begin
            for (i = 0; i < n; i++) begin
                nb.near_x        = nearest_list[i].x;
                nb.near_y        = nearest_list[i].y;
                nb.near_distance = nearest_list[i].distance;
                nb.last_of_run   = (i == n - 1);
                expected_neighbors = {expected_neighbors, nb};
            end
            clear_list();
        end
    endtask

    task automatic compare_neighbor(input neighbor_out_t got);
        neighbor_out_t want;
        if (expected_neighbors.size() == 0) begin
            report_mismatch($sformatf("unexpected neighbor x=%0d y=%0d", got.near_x, got.near_y));
            return;
        end
        want = expected_neighbors.pop_front();
        if (got.near_x !== want.near_x) begin
            report_mismatch($sformatf("near_x %0d, want %0d", got.near_x, want.near_x));
        end
        if (got.near_y !== want.near_y) begin
            report_mismatch($sformatf("near_y %0d, want %0d", got.near_y, want.near_y));
        end
        if (got.near_distance !== want.near_distance) begin
            report_mismatch($sformatf("near_distance %0d, want %0d",
                                      got.near_distance, want.near_distance));
        end
        if (got.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run %b, want %b",
                                      got.last_of_run, want.last_of_run));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       = K_COUNT_RESET;
            query_x_reg = '0;
            query_y_reg = '0;
            clear_list();
            expected_neighbors.delete();
            mismatch_count  = 0;
            pending_results = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_K_COUNT: k_reg = cfg_data[K_W-1:0];
                    REG_QUERY_X: query_x_reg = cfg_data[COORD_BITS-1:0];
                    REG_QUERY_Y: query_y_reg = cfg_data[COORD_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                compare_neighbor(m_data);
            end
            if (s_valid && s_ready) begin
                insert_point(s_data);
            end
            pending_results = expected_neighbors.size();
        end
    end

endmodule

// ----- tb/k_nearest_neighbor_select_test.sv -----
// Testbench top for the k-nearest-neighbor selector: stimulus, idling and verdict.
`timescale 1ns / 100ps

module k_nearest_neighbor_select_test;
    import knn_sel_pkg::*;

    localparam int               SETTLE_CYCLES = 12;
    localparam int               RANDOM_ITEMS  = 210;
    localparam logic [IDX_W-1:0] REG_UNUSED    = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    point_in_t             s_data;
    logic                  m_valid;
    logic                  m_ready;
    neighbor_out_t         m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int                    pending_results;
    int                    mismatch_count;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    logic [COORD_BITS-1:0] query_x_now = '0;
    logic [COORD_BITS-1:0] query_y_now = '0;

    k_nearest_neighbor_select u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    knn_sel_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after the item
    // was taken, with valid still high so a following item can go straight on.
    task automatic send_point(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                              input logic fin);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{point_x: px, point_y: py, final_point: fin};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // The upper data bits are don't-care for k, so they carry random noise.
    task automatic set_k(input logic [K_W-1:0] k);
        logic [CFG_W-1:0] value;
        value = CFG_W'($urandom);
        value[K_W-1:0] = k;
        write_reg(REG_K_COUNT, value);
    endtask

    task automatic set_query(input logic [COORD_BITS-1:0] qx, input logic [COORD_BITS-1:0] qy);
        write_reg(REG_QUERY_X, CFG_W'(qx));
        write_reg(REG_QUERY_Y, CFG_W'(qy));
        query_x_now = qx;
        query_y_now = qy;
    endtask

    // Drains all results, then lets any non-final points in flight settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Many coordinates land close to the query so that equal distances occur.
    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] centre);
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) begin
            return COORD_BITS'($urandom);
        end else if (sel < 8) begin
            return centre + COORD_BITS'($urandom_range(8)) - COORD_BITS'(4);
        end
        return (sel == 8) ? '0 : '1;
    endfunction

    task automatic reconfigure();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            set_k('0);
        end else if (sel == 1) begin
            set_k(K_W'($urandom_range(MAX_NEIGHBORS + 1, 31)));
        end else if (sel == 2) begin
            set_k(K_W'(MAX_NEIGHBORS));
        end else begin
            set_k(K_W'($urandom_range(1, 8)));
        end
        sel = $urandom_range(3);
        if (sel == 0) begin
            set_query('0, '1);
        end else begin
            set_query(COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
    endtask

    task automatic run_random_sets(input int items);
        int left;
        int len;
        int i;
        left = items;
        while (left > 0) begin
            if ($urandom_range(2) == 0) begin
                wait_idle();
                reconfigure();
            end
            len = ($urandom_range(4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 12);
            if (len > left) begin
                len = left;
            end
            for (i = 0; i < len; i++) begin
                // Now and then k changes while the list is partly filled.
                if (i == len / 2 && len > 3 && $urandom_range(7) == 0) begin
                    wait_idle();
                    set_k(K_W'($urandom_range(1, MAX_NEIGHBORS)));
                end
                send_point(pick_coord(query_x_now), pick_coord(query_y_now), i == len - 1);
            end
            left -= len;
        end
    endtask

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 9;
        recv_idle_pct = 64;

        // Reset settings: k of three, query at the origin.
        send_point('0, '0, 1'b0);
        send_point('1, '1, 1'b0);
        send_point('1, '0, 1'b0);
        send_point(16'd3, 16'd4, 1'b0);
        send_point(16'd0, 16'd5, 1'b1);
        // Four points at the same distance: the earliest three are kept.
        send_point(16'd5, 16'd0, 1'b0);
        send_point(16'd4, 16'd3, 1'b0);
        send_point(16'd0, 16'd5, 1'b0);
        send_point(16'd3, 16'd4, 1'b1);
        // A final point on its own still reports itself.
        send_point(16'd7, 16'd7, 1'b1);

        wait_idle();
        write_reg(REG_UNUSED, CFG_W'($urandom));
        set_query('1, '1);
        set_k(K_W'(MAX_NEIGHBORS));
        send_point('0, '0, 1'b0);
        send_point('1, '1, 1'b0);
        send_point('0, '1, 1'b0);
        send_point('1, '0, 1'b0);
        send_point(16'd100, 16'd200, 1'b0);
        send_point('1, '1, 1'b0);
        // Lowering k while entries are held cuts the list at the next point.
        wait_idle();
        set_k(K_W'(2));
        send_point(16'd1, 16'd1, 1'b1);

        wait_idle();
        set_k('0);
        send_point(16'd12, 16'd34, 1'b0);
        send_point('0, '0, 1'b1);
        wait_idle();
        set_k('1);
        send_point(16'hAAAA, 16'h5555, 1'b0);
        send_point(16'h5555, 16'hAAAA, 1'b1);

        run_random_sets(RANDOM_ITEMS / 3);
        wait_idle();
        send_idle_pct = 64;
        recv_idle_pct = 9;
        run_random_sets(RANDOM_ITEMS / 3);
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_sets(RANDOM_ITEMS / 3);

        s_valid <= 1'b0;
        while (pending_results != 0) begin
            @(negedge aclk);
        end
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- k_nearest_neighbor_select.f -----
rtl/knn_sel_pkg.sv
rtl/knn_sel_dist.sv
rtl/knn_sel_cell.sv
rtl/knn_sel_drain_cell.sv
rtl/k_nearest_neighbor_select.sv
tb/knn_sel_checker.sv
tb/k_nearest_neighbor_select_test.sv
